// ===== sv/salfl_pkg.sv =====
package salfl_pkg;

  localparam int NODE_COUNT = 8;
  localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LINK_W     = $clog2(NODE_COUNT + 1);
  localparam int KEY_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 6;

  // The null link is encoded as NODE_COUNT.
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODE_COUNT);

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] key;
  } salfl_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } salfl_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_UPDATE
  } salfl_state_t;

  typedef struct packed {
    logic                load;
    logic                alloc;
    logic                step;
    logic                commit_ins;
    logic                commit_del;
    logic                emit;
    logic [STATUS_W-1:0] status;
  } salfl_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic free_empty;
    logic walk_done;
    logic found;
  } salfl_stat_t;

endpackage

// ===== sv/salfl_ctrl.sv =====
module salfl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  salfl_pkg::salfl_stat_t stat,
  output salfl_pkg::salfl_cmd_t  cmd
);
  import salfl_pkg::*;

  salfl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.is_insert && stat.free_empty) state_nxt = S_IDLE;
        else state_nxt = S_WALK;
      end
      S_WALK: begin
        if (stat.walk_done) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_CHECK: begin
        if (stat.is_insert) begin
          if (stat.free_empty) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_FULL;
          end else begin
            cmd.alloc = 1'b1;
          end
        end
      end
      S_WALK: begin
        cmd.step = !stat.walk_done;
      end
      S_UPDATE: begin
        cmd.emit = 1'b1;
        if (stat.is_insert) begin
          cmd.commit_ins = 1'b1;
          cmd.status     = ST_INSERTED;
        end else if (stat.found) begin
          cmd.commit_del = 1'b1;
          cmd.status     = ST_DELETED;
        end else begin
          cmd.status = ST_NOTFOUND;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/salfl_dp.sv =====
module salfl_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  salfl_pkg::salfl_in_t   in_data,
  input  salfl_pkg::salfl_cmd_t  cmd,
  output salfl_pkg::salfl_stat_t stat,
  output logic                  out_valid,
  output salfl_pkg::salfl_out_t  out_data
);
  import salfl_pkg::*;

  logic [KEY_W-1:0]  key_mem_r  [NODE_COUNT];
  logic [LINK_W-1:0] link_mem_r [NODE_COUNT];
  logic [LINK_W-1:0] free_link_r[NODE_COUNT];

  logic [LINK_W-1:0] head_r, free_head_r;
  logic              action_r;
  logic [KEY_W-1:0]  key_r;
  logic [IDX_W-1:0]  node_r;
  logic [LINK_W-1:0] prev_r, pres_r, steps_r;
  logic              out_valid_r;
  salfl_out_t        out_data_r;

  logic              pres_is_node, prev_is_node;
  logic [IDX_W-1:0]  pres_idx, prev_idx, free_idx;
  logic [KEY_W-1:0]  pres_key;
  logic [LINK_W-1:0] pres_link;
  logic              key_match, key_greater, walk_limit;
  logic [SLOT_W-1:0] emit_slot;

  assign pres_is_node = (pres_r < NIL_LINK);
  assign prev_is_node = (prev_r < NIL_LINK);
  assign pres_idx     = pres_r[IDX_W-1:0];
  assign prev_idx     = prev_r[IDX_W-1:0];
  assign free_idx     = free_head_r[IDX_W-1:0];
  assign pres_key     = key_mem_r[pres_idx];
  assign pres_link    = link_mem_r[pres_idx];
  assign key_match    = (pres_key == key_r);
  assign key_greater  = ($signed(key_r) > $signed(pres_key));
  assign walk_limit   = (steps_r == NIL_LINK);

  always_comb begin
    stat.is_insert  = (action_r == ACT_INSERT);
    stat.free_empty = !(free_head_r < NIL_LINK);
    stat.found      = pres_is_node && key_match;
    if (action_r == ACT_INSERT) begin
      stat.walk_done = !pres_is_node || walk_limit || !key_greater;
    end else begin
      stat.walk_done = !pres_is_node || walk_limit || key_match;
    end
  end

  // Free chain, list head and the result strobe are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        free_link_r[i] <= LINK_W'(i + 1);
      end
      head_r      <= NIL_LINK;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.alloc) begin
        free_head_r <= free_link_r[free_idx];
      end
      if (cmd.commit_ins && !prev_is_node) begin
        head_r <= LINK_W'(node_r);
      end
      if (cmd.commit_del) begin
        if (!prev_is_node) head_r <= pres_link;
        free_link_r[pres_idx] <= free_head_r;
        free_head_r           <= pres_r;
      end
    end
  end

  assign emit_slot = (cmd.status == ST_DELETED) ? SLOT_W'(pres_idx) : SLOT_W'(node_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_data.action;
      key_r    <= in_data.key;
      prev_r   <= NIL_LINK;
      pres_r   <= head_r;
      steps_r  <= '0;
    end
    if (cmd.alloc) begin
      node_r              <= free_idx;
      key_mem_r[free_idx] <= key_r;
    end
    if (cmd.step) begin
      prev_r  <= pres_r;
      pres_r  <= pres_link;
      steps_r <= steps_r + LINK_W'(1);
    end
    if (cmd.commit_ins) begin
      link_mem_r[node_r] <= pres_r;
      if (prev_is_node) link_mem_r[prev_idx] <= LINK_W'(node_r);
    end
    if (cmd.commit_del && prev_is_node) begin
      link_mem_r[prev_idx] <= pres_link;
    end
    if (cmd.emit) begin
      out_data_r.status <= cmd.status;
      if (cmd.status == ST_INSERTED || cmd.status == ST_DELETED) begin
        out_data_r.slot <= emit_slot;
      end else begin
        out_data_r.slot <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/sorted_array_list_with_free_list_top.sv =====
// Channel   Ports                          Transaction
// input     start, busy, in_data           accepted when start is high and busy is low
// result    out_valid, out_data            one-cycle strobe, always taken
//
// An insert passes from acceptance through CHECK, WALK and UPDATE to the result, the walk
// passing n nodes; a delete takes the same states, and a full insert ends in CHECK.
// The walk visits one node per cycle through the key and link store read port.
// Reset (rst_n low, synchronous) empties the list and rebuilds the free chain at once.
// The result is never stalled; a new transaction may be accepted in its cycle.
module sorted_array_list_with_free_list_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  salfl_pkg::salfl_in_t  in_data,
  output logic                 out_valid,
  output salfl_pkg::salfl_out_t out_data
);
  import salfl_pkg::*;

  salfl_cmd_t  cmd;
  salfl_stat_t stat;

  salfl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  salfl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not make the block busy");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL || out_data.status == ST_NOTFOUND))
      |-> (out_data.slot == '0))
    else $error("slot not zero on a dropped or missing-key result");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.alloc, cmd.step, cmd.commit_ins, cmd.commit_del}))
    else $error("datapath received conflicting commands");

endmodule

// ===== dv/sorted_array_list_with_free_list_top_tb.sv =====
`timescale 1ns / 100ps

module sorted_array_list_with_free_list_top_tb;
  import salfl_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_OPS     = 1025;
  localparam int PHASE_LEN      = 40;
  localparam int MAX_REPORTS    = 10;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef logic [LINK_W-1:0] link_t;
  typedef logic signed [KEY_W-1:0] key_t;

  // Tracks the sorted key list and the free chain, and holds the status and slot
  // each accepted operation should produce, oldest first.
  class sorted_list_scoreboard;
    key_t       node_key  [NODE_COUNT];
    link_t      node_next [NODE_COUNT];
    link_t      free_next [NODE_COUNT];
    link_t      list_first;
    link_t      free_first;
    salfl_out_t pending_results[$];
    int         mismatches;

    function new();
      for (int i = 0; i < NODE_COUNT; i++) begin
        node_key[i]  = '0;
        node_next[i] = NIL_LINK;
        free_next[i] = (i + 1 < NODE_COUNT) ? LINK_W'(i + 1) : NIL_LINK;
      end
      list_first = NIL_LINK;
      free_first = '0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s", $time, msg);
      end
    endfunction

    function void predict_op(salfl_in_t op);
      key_t       k;
      link_t      prev;
      link_t      cur;
      link_t      node;
      int         steps;
      salfl_out_t res;
      k          = op.key;
      prev       = NIL_LINK;
      cur        = list_first;
      steps      = 0;
      res.status = ST_NOTFOUND;
      res.slot   = '0;
      if (op.action == ACT_INSERT) begin
        if (free_first >= NIL_LINK) begin
          res.status = ST_FULL;
        end else begin
          node             = free_first;
          free_first       = free_next[node];
          node_key[node]   = k;
          // Stop at the first node whose key is not smaller, so a new key
          // goes in front of equal ones.
          while (cur < NIL_LINK && steps < NODE_COUNT && $signed(k) > $signed(node_key[cur])) begin
            prev = cur;
            cur  = node_next[cur];
            steps++;
          end
          node_next[node] = (cur < NIL_LINK) ? cur : NIL_LINK;
          if (prev < NIL_LINK) begin
            node_next[prev] = node;
          end else begin
            list_first = node;
          end
          res.status = ST_INSERTED;
          res.slot   = SLOT_W'(node);
        end
      end else begin
        while (cur < NIL_LINK && steps < NODE_COUNT && node_key[cur] != k) begin
          prev = cur;
          cur  = node_next[cur];
          steps++;
        end
        if (cur < NIL_LINK && node_key[cur] == k) begin
          if (prev < NIL_LINK) begin
            node_next[prev] = node_next[cur];
          end else begin
            list_first = node_next[cur];
          end
          free_next[cur] = free_first;
          free_first     = cur;
          res.status     = ST_DELETED;
          res.slot       = SLOT_W'(cur);
        end
      end
      pending_results.push_back(res);
    endfunction

    function void check_result(salfl_out_t got);
      salfl_out_t exp;
      if (pending_results.size() == 0) begin
        flag($sformatf("result status=%0d slot=%0d with no transaction pending",
                       got.status, got.slot));
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status || got.slot !== exp.slot) begin
          flag($sformatf("result mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                         exp.status, got.status, exp.slot, got.slot));
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  salfl_in_t  in_data = '0;
  logic       out_valid;
  salfl_out_t out_data;

  sorted_list_scoreboard sb = new();
  int   idle_cycles = 0;
  int   gap_mode = 0;
  key_t recent_keys[$];

  sorted_array_list_with_free_list_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results are checked before the new transaction is noted, so a result
  // that shares its edge with an acceptance is matched to the older one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_result(out_data);
      end
      if (start && !busy) begin
        sb.predict_op(in_data);
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    case (gap_mode)
      0: return 0;
      1: return $urandom_range(0, 2);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  task automatic send_op(logic act, key_t k);
    int        gap;
    salfl_in_t op;
    gap       = pick_gap();
    op.action = act;
    op.key    = k;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= op;
    if (act == ACT_INSERT) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > 16) begin
        void'(recent_keys.pop_front());
      end
    end
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic key_t pick_insert_key();
    case ($urandom_range(0, 3))
      0, 1: return key_t'($urandom);
      2: return key_t'($urandom_range(0, 8)) - 32'sd4;
      default: begin
        case ($urandom_range(0, 3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
    endcase
  endfunction

  function automatic key_t pick_delete_key();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7 && recent_keys.size() > 0) begin
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    end else if (roll < 9) begin
      return key_t'($urandom_range(0, 8)) - 32'sd4;
    end
    return key_t'($urandom);
  endfunction

  task automatic run_directed();
    gap_mode = 2;
    send_op(ACT_DELETE, 32'sd0);
    send_op(ACT_INSERT, 32'sd0);
    send_op(ACT_INSERT, KEY_MAX);
    send_op(ACT_INSERT, KEY_MIN);
    send_op(ACT_INSERT, -32'sd1);
    send_op(ACT_INSERT, 32'sd5);
    send_op(ACT_INSERT, 32'sd5);
    send_op(ACT_INSERT, -32'sd1);
    send_op(ACT_INSERT, 32'sd1);
    // Every node is now in use.
    send_op(ACT_INSERT, 32'sd7);
    send_op(ACT_DELETE, 32'sd3);
    send_op(ACT_DELETE, 32'sd5);
    send_op(ACT_DELETE, KEY_MIN);
    send_op(ACT_DELETE, KEY_MAX);
    send_op(ACT_INSERT, 32'sd100);
    send_op(ACT_DELETE, 32'sd5);
    send_op(ACT_DELETE, -32'sd1);
    send_op(ACT_DELETE, -32'sd1);
    send_op(ACT_DELETE, 32'sd0);
    send_op(ACT_DELETE, 32'sd1);
    send_op(ACT_DELETE, 32'sd100);
    send_op(ACT_DELETE, 32'sd100);
  endtask

  task automatic run_random();
    int insert_pct;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % PHASE_LEN == 0) begin
        // Alternate between filling and draining so the list often runs full and empty.
        insert_pct = ((n / PHASE_LEN) % 2 == 0) ? 75 : 30;
        gap_mode   = (n / PHASE_LEN) % 3;
      end
      if ($urandom_range(0, 99) < insert_pct) begin
        send_op(ACT_INSERT, pick_insert_key());
      end else begin
        send_op(ACT_DELETE, pick_delete_key());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
